// ----- hw/rtl/lecm_pkg.sv -----
// shared constants, types and constant tables of the lfo cutoff modulator
`default_nettype none

package lecm_pkg;

    localparam int PHASE_BITS       = 32;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int EXP_TABLE_DEPTH  = 256;

    localparam int CUTOFF_W   = 19;
    localparam int BLK_W      = 14;
    localparam int WAVE_W     = 16;
    localparam int DEPTH_W    = 15;
    localparam int INC_W      = 32;
    localparam int WTYPE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int EXP_W      = 17;
    localparam int OCT_W      = 21;
    localparam int MUL_IN_W   = 33;
    localparam int MUL_W      = 48;
    localparam int PROD_CUT_W = CUTOFF_W + EXP_W;
    localparam int SIN_IW     = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int EXP_IW     = $clog2(EXP_TABLE_DEPTH);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH     = 2'd2;

    // waveform codes
    localparam logic [WTYPE_W-1:0] WAVE_SINE     = 2'd0;
    localparam logic [WTYPE_W-1:0] WAVE_SQUARE   = 2'd1;
    localparam logic [WTYPE_W-1:0] WAVE_TRIANGLE = 2'd2;
    localparam logic [WTYPE_W-1:0] WAVE_SAW      = 2'd3;

    localparam logic [WTYPE_W-1:0]        WAVE_TYPE_RESET = WAVE_SINE;
    localparam logic [INC_W-1:0]          PHASE_INC_RESET = 32'd429497;
    localparam logic signed [DEPTH_W-1:0] DEPTH_RESET     = 15'sd256;

    localparam logic [CUTOFF_W-1:0] CUT_MIN = 19'd336;
    localparam logic [CUTOFF_W-1:0] CUT_MAX = 19'd319840;

    // floor divide by 3 of a biased 23-bit value: z * ceil(2^25 / 3) >> 25
    localparam logic [23:0]  DIV_BIAS   = 24'd6291456;
    localparam logic [21:0]  DIV_OFFSET = 22'd2097152;
    localparam logic [MUL_IN_W-1:0] DIV3_RECIP = 33'd11184811;
    localparam int DIV3_SHIFT = 25;

    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
    localparam logic [63:0] Q30_LN2     = 64'd744261118;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_PHASE,
        ST_DIV,
        ST_EXP,
        ST_MANT,
        ST_CUT,
        ST_SCALE
    } state_t;

    // quarter-wave sine, Q1.15, rounded, from a Q30 series
    function automatic logic [(SINE_TABLE_DEPTH+1)*WAVE_W-1:0] build_sin_tab();
        logic [(SINE_TABLE_DEPTH+1)*WAVE_W-1:0] tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      v;
        tab = '0;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            x    = Q30_HALF_PI * 64'(k) / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 6; n++)
            begin
                term = (term * x2) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if ((n & 1) != 0)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            v = (sum + 16384) >>> 15;
            if (v > 32767)
                v = 32767;
            tab[k*WAVE_W +: WAVE_W] = v[WAVE_W-1:0];
        end
        return tab;
    endfunction

    // 2^(k/depth) in Q16, rounded
    function automatic logic [EXP_TABLE_DEPTH*EXP_W-1:0] build_exp_tab();
        logic [EXP_TABLE_DEPTH*EXP_W-1:0] tab;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        tab = '0;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++)
        begin
            y    = Q30_LN2 * 64'(k) / 64'(EXP_TABLE_DEPTH);
            term = 64'd1 << 30;
            sum  = term;
            for (int n = 1; n <= 12; n++)
            begin
                term = ((term * y) >> 30) / 64'(n);
                sum  = sum + term;
            end
            r = (sum + 64'd8192) >> 14;
            tab[k*EXP_W +: EXP_W] = r[EXP_W-1:0];
        end
        return tab;
    endfunction

    localparam logic [(SINE_TABLE_DEPTH+1)*WAVE_W-1:0] SIN_TAB = build_sin_tab();
    localparam logic [EXP_TABLE_DEPTH*EXP_W-1:0]       EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

// ----- hw/rtl/lecm_if.sv -----
// valid/ready channel interfaces: input item, result item, register write
`default_nettype none

interface lecm_item_if
    import lecm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CUTOFF_W-1:0] cutoff_q4;
    logic [BLK_W-1:0]    block_samples;

    modport source (output valid, output cutoff_q4, output block_samples, input ready);
    modport sink   (input valid, input cutoff_q4, input block_samples, output ready);
endinterface

interface lecm_result_if
    import lecm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CUTOFF_W-1:0]      modulated_cutoff_q4;
    logic signed [WAVE_W-1:0] wave_value;

    modport source (output valid, output modulated_cutoff_q4, output wave_value, input ready);
    modport sink   (input valid, input modulated_cutoff_q4, input wave_value, output ready);
endinterface

interface lecm_cfg_if
    import lecm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lfo_exponential_cutoff_modulator.sv -----
// lfo cutoff modulator top level: sequencer around one shared multiplier
//
//  channel  dir  fields                                  accepted when
//  item     in   cutoff_q4[18:0] block_samples[13:0]     item.valid && item.ready
//  result   out  modulated_cutoff_q4[18:0] wave_value    result.valid && result.ready
//  cfg      in   index[1:0] data[31:0]                   cfg.valid && cfg.ready
//
// one item runs from the idle accept through seven sequencer steps to result load,
// four of them passes through the shared 33x33 multiplier
// (phase step, depth times wave, divide by 3, cutoff times mantissa)
// a finished result sits in the output register; the next item is taken meanwhile,
// and the last step waits only if the output register is still full
// async active-low reset clears phase, state and result valid and loads the config registers with their reset values
`default_nettype none

module lfo_exponential_cutoff_modulator
    import lecm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    lecm_item_if.sink      item,
    lecm_result_if.source  result,
    lecm_cfg_if.sink       cfg
);

    state_t state_reg;
    state_t state_next;

    logic [PHASE_BITS-1:0]    phase_reg;
    logic [PHASE_BITS-1:0]    phase_next;
    logic [WTYPE_W-1:0]       wave_type_reg;
    logic [INC_W-1:0]         phase_inc_reg;
    logic signed [DEPTH_W-1:0] depth_reg;

    logic [CUTOFF_W-1:0]      cutoff_reg;
    logic [BLK_W-1:0]         blk_reg;
    logic signed [WAVE_W-1:0] wave_reg;
    logic signed [WAVE_W-1:0] wave_next;
    logic [MUL_W-1:0]         prod_reg;
    logic [MUL_W-1:0]         prod_next;
    logic [OCT_W-1:0]         oct_reg;
    logic [OCT_W-1:0]         oct_next;
    logic [EXP_W-1:0]         mant_reg;
    logic [EXP_W-1:0]         mant_next;

    logic                     out_valid_reg;
    logic [CUTOFF_W-1:0]      res_cutoff_reg;
    logic [CUTOFF_W-1:0]      res_cutoff_next;
    logic signed [WAVE_W-1:0] res_wave_reg;

    logic item_ready;
    logic item_accept;
    logic mul_en;
    logic out_load;

    logic signed [MUL_IN_W-1:0]   mul_a;
    logic signed [MUL_IN_W-1:0]   mul_b;
    logic signed [2*MUL_IN_W-1:0] mul_p;

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    logic [23:0] z_wide;
    logic [22:0] z_div;

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        mul_en     = 1'b0;
        out_load   = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item.valid)
                    state_next = ST_ADV;
            end
            ST_ADV:
            begin
                mul_en     = 1'b1;
                mul_a      = $signed({{(MUL_IN_W-BLK_W){1'b0}}, blk_reg});
                mul_b      = $signed({{(MUL_IN_W-INC_W){1'b0}}, phase_inc_reg});
                state_next = ST_PHASE;
            end
            ST_PHASE:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_IN_W'(depth_reg);
                mul_b      = MUL_IN_W'(wave_reg);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                mul_en     = 1'b1;
                mul_a      = $signed({{(MUL_IN_W-23){1'b0}}, z_div});
                mul_b      = $signed(DIV3_RECIP);
                state_next = ST_EXP;
            end
            ST_EXP:
                state_next = ST_MANT;
            ST_MANT:
                state_next = ST_CUT;
            ST_CUT:
            begin
                mul_en     = 1'b1;
                mul_a      = $signed({{(MUL_IN_W-CUTOFF_W){1'b0}}, cutoff_reg});
                mul_b      = $signed({{(MUL_IN_W-EXP_W){1'b0}}, mant_reg});
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign item.ready  = item_ready;
    assign item_accept = item.valid && item_ready;

    // the shared multiplier
    assign mul_p     = mul_a * mul_b;
    assign prod_next = mul_p[MUL_W-1:0];

    // ---------------- waveform from the phase before advancing ----------------
    logic [15:0]                p;
    logic [14+SIN_IW-1:0]       sin_prod;
    logic [SIN_IW-1:0]          sin_i;
    logic [SIN_IW-1:0]          sin_addr;
    logic [WAVE_W-1:0]          sin_val;
    logic [16:0]                tri_d;
    logic signed [17:0]         wave_wide;

    assign p        = phase_reg[PHASE_BITS-1 -: 16];
    assign sin_prod = (14+SIN_IW)'(p[13:0]) * (14+SIN_IW)'(SINE_TABLE_DEPTH);
    assign sin_i    = sin_prod[14 +: SIN_IW];
    // odd quadrants run the table backwards
    assign sin_addr = p[14] ? (SIN_IW'(SINE_TABLE_DEPTH) - sin_i) : sin_i;
    assign sin_val  = SIN_TAB[sin_addr*WAVE_W +: WAVE_W];
    assign tri_d    = p[15] ? ({1'b0, p} - 17'd32768) : (17'd32768 - {1'b0, p});

    always_comb
    begin
        case (wave_type_reg)
            WAVE_SINE:
                wave_wide = p[15] ? -$signed({2'b00, sin_val}) : $signed({2'b00, sin_val});
            WAVE_SQUARE:
                wave_wide = p[15] ? -18'sd32768 : 18'sd32767;
            WAVE_TRIANGLE:
                wave_wide = $signed({tri_d, 1'b0}) - 18'sd32768;
            WAVE_SAW:
                wave_wide = 18'sd32768 - $signed({2'b00, p});
            default:
                wave_wide = '0;
        endcase
        if (wave_wide > 18'sd32767)
            wave_next = 16'sd32767;
        else if (wave_wide < -18'sd32768)
            wave_next = -16'sd32768;
        else
            wave_next = wave_wide[WAVE_W-1:0];
    end

    // ---------------- phase advance ----------------
    logic [PHASE_BITS+MUL_W-1:0] phase_sum;
    assign phase_sum  = (PHASE_BITS+MUL_W)'(phase_reg) + (PHASE_BITS+MUL_W)'(prod_reg);
    assign phase_next = phase_sum[PHASE_BITS-1:0];

    // ---------------- octaves = floor(depth * wave / 1536) ----------------
    // floor by 512 is an arithmetic shift, then a biased floor divide by 3
    logic signed [21:0] y_div;
    logic [21:0]        q_div;
    logic [21:0]        oct_wide;

    assign y_div    = $signed(prod_reg[30:9]);
    assign z_wide   = {{2{y_div[21]}}, y_div} + DIV_BIAS;
    assign z_div    = z_wide[22:0];
    assign q_div    = prod_reg[DIV3_SHIFT +: 22];
    assign oct_wide = q_div - DIV_OFFSET;
    assign oct_next = oct_wide[OCT_W-1:0];

    // ---------------- mantissa lookup ----------------
    logic [16+EXP_IW-1:0] exp_prod;
    logic [EXP_IW-1:0]    exp_idx;

    assign exp_prod  = (16+EXP_IW)'(oct_reg[15:0]) * (16+EXP_IW)'(EXP_TABLE_DEPTH);
    assign exp_idx   = exp_prod[16 +: EXP_IW];
    assign mant_next = EXP_TAB[exp_idx*EXP_W +: EXP_W];

    // ---------------- shift by whole octaves and clamp ----------------
    logic signed [OCT_W-17:0] oct_int;
    logic [OCT_W-17:0]        oct_neg;
    logic [5:0]               rshift;
    logic [51:0]              scaled;

    assign oct_int = $signed(oct_reg[OCT_W-1:16]);
    assign oct_neg = $unsigned(-oct_int);
    assign rshift  = 6'd16 + {1'b0, oct_neg};

    always_comb
    begin
        if (!oct_int[OCT_W-17])
            scaled = (52'(prod_reg[PROD_CUT_W-1:0]) << oct_int[OCT_W-18:0]) >> 16;
        else
            scaled = 52'(prod_reg[PROD_CUT_W-1:0]) >> rshift;
        if (scaled < 52'(CUT_MIN))
            res_cutoff_next = CUT_MIN;
        else if (scaled > 52'(CUT_MAX))
            res_cutoff_next = CUT_MAX;
        else
            res_cutoff_next = scaled[CUTOFF_W-1:0];
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            cutoff_reg <= item.cutoff_q4;
            blk_reg    <= item.block_samples;
        end
        if (state_reg == ST_ADV)
            wave_reg <= wave_next;
        if (mul_en)
            prod_reg <= prod_next;
        if (state_reg == ST_EXP)
            oct_reg <= oct_next;
        if (state_reg == ST_MANT)
            mant_reg <= mant_next;
        if (out_load)
        begin
            res_cutoff_reg <= res_cutoff_next;
            res_wave_reg   <= wave_reg;
        end
    end

    // ---------------- phase, registers, result valid ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            wave_type_reg <= WAVE_TYPE_RESET;
            phase_inc_reg <= PHASE_INC_RESET;
            depth_reg     <= DEPTH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_PHASE)
                phase_reg <= phase_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_WAVE_TYPE: wave_type_reg <= cfg.data[WTYPE_W-1:0];
                    REG_PHASE_INC: phase_inc_reg <= cfg.data[INC_W-1:0];
                    REG_DEPTH:     depth_reg     <= $signed(cfg.data[DEPTH_W-1:0]);
                    default:       ;
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign cfg.ready                  = 1'b1;
    assign result.valid               = out_valid_reg;
    assign result.modulated_cutoff_q4 = res_cutoff_reg;
    assign result.wave_value          = res_wave_reg;

    // ---------------- assertions ----------------
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_accept |=> !item.ready)
        else $error("item taken while the sequencer is busy");

    a_phase_moves_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_PHASE) |=> $stable(phase_reg))
        else $error("phase changed outside its advance step");

    a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.modulated_cutoff_q4 >= CUT_MIN &&
                          result.modulated_cutoff_q4 <= CUT_MAX))
        else $error("result cutoff outside the clamp range");

endmodule

`default_nettype wire
